// ===== src/fspd_pkg.sv =====
`default_nettype none

package fspd_pkg;

    localparam int PILOT_TAPS_DEF  = 127;
    localparam int AUDIO_TAPS_DEF  = 127;
    localparam int SINE_BITS_DEF   = 10;
    localparam int COEF_W          = 18;
    localparam int SAMPLE_W        = 16;
    localparam int PROD_W          = COEF_W + SAMPLE_W;
    localparam int ACC_W_DEF       = PROD_W + 9;

    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_LOAD_PILOT = 2'd1;
    localparam logic [1:0] OP_LOAD_AUDIO = 2'd2;

    localparam logic [2:0] REG_LOW_PASS  = 3'd0;
    localparam logic [2:0] REG_NOMINAL   = 3'd1;
    localparam logic [2:0] REG_MIN_OMEGA = 3'd2;
    localparam logic [2:0] REG_MAX_OMEGA = 3'd3;
    localparam logic [2:0] REG_ALPHA     = 3'd4;
    localparam logic [2:0] REG_BETA      = 3'd5;

    localparam logic [31:0] NOMINAL_RST = 32'd429496730;
    localparam logic [31:0] MIN_RST     = 32'd419430400;
    localparam logic [31:0] MAX_RST     = 32'd440401920;
    localparam logic [23:0] ALPHA_RST   = 24'd50000;
    localparam logic [23:0] BETA_RST    = 24'd200;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic clr;
        logic en;
    } mac_ctrl_t;

    // one quarter-wave entry, taylor series in Q30, rounded to Q1.15
    function automatic logic [14:0] qsine_entry(input int unsigned idx,
                                                input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] tmp;
        logic [63:0] q;
        logic signed [63:0] s;
        x = (64'(idx) * HALF_PI_Q30) >> (bits - 2);
        x2 = (x * x) >> 30;
        term = x;
        s = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            tmp = (term * x2) >> 30;
            case (n)
                1: term = tmp / 64'd6;
                2: term = tmp / 64'd20;
                3: term = tmp / 64'd42;
                4: term = tmp / 64'd72;
                5: term = tmp / 64'd110;
                6: term = tmp / 64'd156;
                default: term = tmp / 64'd210;
            endcase
            if ((n & 1) == 1) s = s - $signed(term);
            else s = s + $signed(term);
        end
        q = (s > 0) ? ((64'(s) + 64'd16384) >> 15) : 64'd0;
        return (q > 64'd32767) ? 15'd32767 : q[14:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/fspd_mac.sv =====
`default_nettype none

module fspd_mac #(
    parameter int ACC_W = fspd_pkg::ACC_W_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire fspd_pkg::mac_ctrl_t                   ctrl,
    input  wire logic signed [fspd_pkg::COEF_W-1:0]    coef,
    input  wire logic signed [fspd_pkg::SAMPLE_W-1:0]  sample,
    output logic signed [ACC_W-1:0]                    acc
);
    import fspd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     en_d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
        acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef * sample;
        if (!aresetn) begin
            en_d_reg <= 1'b0;
        end else begin
            en_d_reg <= ctrl.en && !ctrl.clr;
        end
        if (ctrl.clr) begin
            acc_reg <= '0;
        end else if (en_d_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== src/fm_stereo_pilot_pll_decoder.sv =====
// sample word: from accept to m_tvalid it passes PHASE, SINE, MIX and DIFF, one
// tap walk through the coefficient and delay-line memories, then DRAIN, FIR, ERR0, ERR1, GAIN, STEP, PHUP and OUT
// a new sample word is taken only after the last one has left OUT; s_tready is low until then
// load words give no result; a waiting result holds the next sample
// in its last step; after reset a clearing pass zeros the delay lines (after low_pass_enable
// changes, only the audio lines) while s_tready is low
`default_nettype none

module fm_stereo_pilot_pll_decoder #(
    parameter int PILOT_TAPS      = fspd_pkg::PILOT_TAPS_DEF,
    parameter int AUDIO_TAPS      = fspd_pkg::AUDIO_TAPS_DEF,
    parameter int SINE_TABLE_BITS = fspd_pkg::SINE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // tap_index, coefficient, mpx_sample
    input  wire logic [1:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // left_out, right_out
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data
);
    import fspd_pkg::*;

    localparam int TMAX    = (PILOT_TAPS > AUDIO_TAPS) ? PILOT_TAPS : AUDIO_TAPS;
    localparam int GD      = (PILOT_TAPS - 1) / 2;
    localparam int ALIGN   = GD + 1;
    localparam int PW      = $clog2(PILOT_TAPS);
    localparam int AAW     = $clog2(AUDIO_TAPS);
    localparam int ALW     = $clog2(ALIGN);
    localparam int KW      = $clog2(TMAX);
    localparam int ACC_W   = PROD_W + KW + 1;
    localparam int FIR_W   = ACC_W - 16;
    localparam int P1_W    = FIR_W + SAMPLE_W;
    localparam int P20_W   = P1_W + 5;
    localparam int SB      = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (SB - 2);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PHASE = 4'd1;
    localparam logic [3:0] ST_SINE  = 4'd2;
    localparam logic [3:0] ST_MIX   = 4'd3;
    localparam logic [3:0] ST_DIFF  = 4'd4;
    localparam logic [3:0] ST_WALK  = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_FIR   = 4'd7;
    localparam logic [3:0] ST_ERR0  = 4'd8;
    localparam logic [3:0] ST_ERR1  = 4'd9;
    localparam logic [3:0] ST_GAIN  = 4'd10;
    localparam logic [3:0] ST_STEP  = 4'd11;
    localparam logic [3:0] ST_PHUP  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    localparam logic signed [ACC_W:0]   HALF17 = (ACC_W+1)'(65536);
    localparam logic signed [P20_W-1:0] LIM30  = P20_W'(64'd1073741824);
    localparam logic signed [P20_W-1:0] NLIM30 = -LIM30;
    localparam logic signed [P20_W-1:0] HALF15 = P20_W'(16384);
    localparam logic signed [42:0]      HALF15G = 43'sd16384;
    localparam logic signed [32:0]      HALF14 = 33'sd8192;

    typedef logic [14:0] qtab_t [QUARTER+1];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i <= QUARTER; i++) begin
            t[i] = qsine_entry(i, SB);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    function automatic logic signed [15:0] sine_lu(input logic [31:0] ph);
        logic [SB-1:0] j;
        logic [SB-2:0] ix;
        logic [14:0]   v;
        j = ph[31 -: SB];
        ix = j[SB-2] ? ((SB-1)'(QUARTER) - {1'b0, j[SB-3:0]}) : {1'b0, j[SB-3:0]};
        v = QTAB[ix];
        return j[SB-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic logic signed [15:0] sat_mix(input logic signed [32:0] v);
        if (v > 33'sd32767) return 16'sh7fff;
        if (v < -33'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] sat_out(input logic signed [FIR_W:0] v);
        if (v > (FIR_W+1)'(32767)) return 16'sh7fff;
        if (v < -(FIR_W+1)'(32768)) return 16'sh8000;
        return v[15:0];
    endfunction

    // configuration
    logic        lpe_reg;
    logic [31:0] min_reg, max_reg;
    logic [23:0] alpha_reg, beta_reg;

    // control
    logic [3:0]     state_reg;
    logic [KW-1:0]  k_reg;
    logic [1:0]     drain_reg;
    logic [PW-1:0]  fp_reg, pa_reg;
    logic [AAW-1:0] audp_reg, aa_reg;
    logic [ALW-1:0] ap_reg;
    logic           clr_p_reg, clr_a_reg;
    logic [KW-1:0]  clr_cnt_reg;
    logic           p_rdv_reg, a_rdv_reg;
    logic           m_tvalid_reg;

    // datapath
    logic [31:0]              vco_phase_reg, vco_step_reg, dphase_reg;
    logic signed [15:0]       sn_reg, cs_reg, diffin_reg;
    logic signed [31:0]       mix_reg;
    logic signed [FIR_W-1:0]  pilot_reg, sumf_reg, difff_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic signed [16:0]       e_reg;
    logic signed [41:0]       ka_reg, kb_reg;
    logic [31:0]              ra_reg;
    logic [31:0]              m_tdata_reg;

    // memories and read data
    logic signed [17:0] pcoef_mem [PILOT_TAPS];
    logic signed [17:0] acoef_mem [AUDIO_TAPS];
    logic signed [15:0] pline_mem [PILOT_TAPS];
    logic signed [15:0] sline_mem [AUDIO_TAPS];
    logic signed [15:0] dline_mem [AUDIO_TAPS];
    logic signed [15:0] align_mem [ALIGN];
    logic signed [17:0] pcoef_rd, acoef_rd;
    logic signed [15:0] pline_rd, sline_rd, dline_rd, align_rd;

    logic [6:0]          in_idx;
    logic signed [17:0]  in_coef;
    logic signed [15:0]  in_x;
    logic                accept, acc_sample, load_p, load_a;
    logic                clearing, p_issue, a_issue;
    logic                pl_we, al_we, au_we;
    logic [PW-1:0]       pl_wa;
    logic [ALW-1:0]      al_wa;
    logic [AAW-1:0]      au_wa;
    logic signed [15:0]  pl_wd, al_wd, sl_wd, dl_wd;
    mac_ctrl_t           p_ctrl, a_ctrl;
    logic signed [ACC_W-1:0] acc_p, acc_s, acc_d;

    assign in_idx  = s_tdata[6:0];
    assign in_coef = s_tdata[24:7];
    assign in_x    = s_tdata[40:25];

    assign clearing   = clr_p_reg || clr_a_reg;
    assign s_tready   = (state_reg == ST_IDLE) && !clearing;
    assign accept     = s_tvalid && s_tready;
    assign acc_sample = accept && (s_tuser == OP_SAMPLE);
    assign load_p     = accept && (s_tuser == OP_LOAD_PILOT) && (int'(in_idx) < PILOT_TAPS);
    assign load_a     = accept && (s_tuser == OP_LOAD_AUDIO) && (int'(in_idx) < AUDIO_TAPS);

    assign p_issue = (state_reg == ST_WALK) && (int'(k_reg) < PILOT_TAPS);
    assign a_issue = (state_reg == ST_WALK) && (int'(k_reg) < AUDIO_TAPS);

    always_comb begin
        pl_we = acc_sample || (clr_p_reg && int'(clr_cnt_reg) < PILOT_TAPS);
        pl_wa = clr_p_reg ? clr_cnt_reg[PW-1:0] : fp_reg;
        pl_wd = clr_p_reg ? 16'sd0 : in_x;
        al_we = acc_sample || (clr_p_reg && int'(clr_cnt_reg) < ALIGN);
        al_wa = clr_p_reg ? clr_cnt_reg[ALW-1:0] : ap_reg;
        al_wd = clr_p_reg ? 16'sd0 : in_x;
        au_we = ((state_reg == ST_DIFF) && lpe_reg) ||
                (clr_a_reg && int'(clr_cnt_reg) < AUDIO_TAPS);
        au_wa = clr_a_reg ? clr_cnt_reg[AAW-1:0] : audp_reg;
        sl_wd = clr_a_reg ? 16'sd0 : align_rd;
        dl_wd = clr_a_reg ? 16'sd0
                          : sat_mix(($signed({mix_reg[31], mix_reg}) + HALF14) >>> 14);
    end

    always_ff @(posedge aclk) begin
        if (load_p) pcoef_mem[PW'(in_idx)] <= in_coef;
        if (p_issue) pcoef_rd <= pcoef_mem[k_reg[PW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (load_a) acoef_mem[AAW'(in_idx)] <= in_coef;
        if (a_issue) acoef_rd <= acoef_mem[k_reg[AAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pl_we) pline_mem[pl_wa] <= pl_wd;
        if (p_issue) pline_rd <= pline_mem[pa_reg];
    end

    always_ff @(posedge aclk) begin
        if (au_we) sline_mem[au_wa] <= sl_wd;
        if (a_issue) sline_rd <= sline_mem[aa_reg];
    end

    always_ff @(posedge aclk) begin
        if (au_we) dline_mem[au_wa] <= dl_wd;
        if (a_issue) dline_rd <= dline_mem[aa_reg];
    end

    // read-first: the word leaving the align line is the one aligned with the pilot
    always_ff @(posedge aclk) begin
        if (acc_sample) align_rd <= align_mem[ap_reg];
        if (al_we) align_mem[al_wa] <= al_wd;
    end

    assign p_ctrl = '{clr: (state_reg == ST_DIFF), en: p_rdv_reg};
    assign a_ctrl = '{clr: (state_reg == ST_DIFF), en: a_rdv_reg};

    fspd_mac #(.ACC_W(ACC_W)) u_mac_pilot (
        .aclk(aclk), .aresetn(aresetn), .ctrl(p_ctrl),
        .coef(pcoef_rd), .sample(pline_rd), .acc(acc_p)
    );

    fspd_mac #(.ACC_W(ACC_W)) u_mac_sum (
        .aclk(aclk), .aresetn(aresetn), .ctrl(a_ctrl),
        .coef(acoef_rd), .sample(sline_rd), .acc(acc_s)
    );

    fspd_mac #(.ACC_W(ACC_W)) u_mac_diff (
        .aclk(aclk), .aresetn(aresetn), .ctrl(a_ctrl),
        .coef(acoef_rd), .sample(dline_rd), .acc(acc_d)
    );

    // datapath stages
    logic signed [ACC_W:0]   rnd_p, rnd_s, rnd_d;
    logic signed [P20_W-1:0] p20, p20r;
    logic signed [42:0]      ra_full, rb_full;
    logic signed [33:0]      step_next;
    logic signed [FIR_W-1:0] sum_sel, diff_sel;
    logic signed [FIR_W:0]   left_w, right_w;

    always_comb begin
        rnd_p = ($signed({acc_p[ACC_W-1], acc_p}) + HALF17) >>> 17;
        rnd_s = ($signed({acc_s[ACC_W-1], acc_s}) + HALF17) >>> 17;
        rnd_d = ($signed({acc_d[ACC_W-1], acc_d}) + HALF17) >>> 17;
        p20 = ({{5{p1_reg[P1_W-1]}}, p1_reg} <<< 4) + ({{5{p1_reg[P1_W-1]}}, p1_reg} <<< 2);
        p20r = (p20 + HALF15) >>> 15;
        ra_full = ($signed({ka_reg[41], ka_reg}) + HALF15G) >>> 15;
        rb_full = ($signed({kb_reg[41], kb_reg}) + HALF15G) >>> 15;
        step_next = $signed({2'b00, vco_step_reg}) + rb_full[33:0];
        if (step_next < $signed({2'b00, min_reg})) step_next = $signed({2'b00, min_reg});
        if (step_next > $signed({2'b00, max_reg})) step_next = $signed({2'b00, max_reg});
        sum_sel  = lpe_reg ? sumf_reg : FIR_W'(align_rd);
        diff_sel = lpe_reg ? difff_reg : FIR_W'(diffin_reg);
        left_w   = {sum_sel[FIR_W-1], sum_sel} + {diff_sel[FIR_W-1], diff_sel};
        right_w  = {sum_sel[FIR_W-1], sum_sel} - {diff_sel[FIR_W-1], diff_sel};
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_PHASE: dphase_reg <= vco_phase_reg - 32'(GD) * vco_step_reg;
            ST_SINE: begin
                sn_reg <= sine_lu(dphase_reg);
                cs_reg <= sine_lu({dphase_reg[30:0], 1'b0} + 32'h4000_0000);
            end
            ST_MIX:  mix_reg <= align_rd * cs_reg;
            ST_DIFF: diffin_reg <= dl_wd;
            ST_FIR: begin
                pilot_reg <= rnd_p[FIR_W-1:0];
                sumf_reg  <= rnd_s[FIR_W-1:0];
                difff_reg <= rnd_d[FIR_W-1:0];
            end
            ST_ERR0: p1_reg <= pilot_reg * sn_reg;
            ST_ERR1: begin
                if (p20 >= LIM30) e_reg <= 17'sd32768;
                else if (p20 <= NLIM30) e_reg <= -17'sd32768;
                else e_reg <= p20r[16:0];
            end
            ST_GAIN: begin
                ka_reg <= $signed({1'b0, alpha_reg}) * e_reg;
                kb_reg <= $signed({1'b0, beta_reg}) * e_reg;
            end
            ST_STEP: ra_reg <= ra_full[31:0];
            default: ;
        endcase
    end

    // control, state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            drain_reg     <= '0;
            fp_reg        <= '0;
            pa_reg        <= '0;
            audp_reg      <= '0;
            aa_reg        <= '0;
            ap_reg        <= '0;
            clr_p_reg     <= 1'b1;
            clr_a_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            p_rdv_reg     <= 1'b0;
            a_rdv_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            vco_phase_reg <= '0;
            vco_step_reg  <= NOMINAL_RST;
            lpe_reg       <= 1'b1;
            min_reg       <= MIN_RST;
            max_reg       <= MAX_RST;
            alpha_reg     <= ALPHA_RST;
            beta_reg      <= BETA_RST;
        end else begin
            p_rdv_reg <= p_issue;
            a_rdv_reg <= a_issue;
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) m_tvalid_reg <= 1'b0;

            if (clearing) begin
                if (clr_cnt_reg == KW'(TMAX - 1)) begin
                    clr_p_reg <= 1'b0;
                    clr_a_reg <= 1'b0;
                end else begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (acc_sample) begin
                        ap_reg <= (ap_reg == ALW'(ALIGN - 1)) ? '0 : ap_reg + 1'b1;
                        state_reg <= ST_PHASE;
                    end
                end
                ST_PHASE: state_reg <= ST_SINE;
                ST_SINE:  state_reg <= ST_MIX;
                ST_MIX:   state_reg <= ST_DIFF;
                ST_DIFF: begin
                    pa_reg <= fp_reg;
                    fp_reg <= (fp_reg == PW'(PILOT_TAPS - 1)) ? '0 : fp_reg + 1'b1;
                    aa_reg <= audp_reg;
                    if (lpe_reg) begin
                        audp_reg <= (audp_reg == AAW'(AUDIO_TAPS - 1)) ? '0
                                                                       : audp_reg + 1'b1;
                    end
                    k_reg <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    // newest sample first, walking back through each line
                    pa_reg <= (pa_reg == '0) ? PW'(PILOT_TAPS - 1) : pa_reg - 1'b1;
                    aa_reg <= (aa_reg == '0) ? AAW'(AUDIO_TAPS - 1) : aa_reg - 1'b1;
                    if (k_reg == KW'(TMAX - 1)) begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 2'd1) state_reg <= ST_FIR;
                end
                ST_FIR:  state_reg <= ST_ERR0;
                ST_ERR0: state_reg <= ST_ERR1;
                ST_ERR1: state_reg <= ST_GAIN;
                ST_GAIN: state_reg <= ST_STEP;
                ST_STEP: begin
                    vco_step_reg <= step_next[31:0];
                    state_reg <= ST_PHUP;
                end
                ST_PHUP: begin
                    vco_phase_reg <= vco_phase_reg + vco_step_reg + ra_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {sat_out(right_w), sat_out(left_w)};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LOW_PASS: begin
                        if (cfg_wr_data[0] != lpe_reg) begin
                            clr_a_reg   <= 1'b1;
                            clr_cnt_reg <= '0;
                            audp_reg    <= '0;
                        end
                        lpe_reg <= cfg_wr_data[0];
                    end
                    REG_NOMINAL: begin
                        vco_step_reg  <= cfg_wr_data;
                        vco_phase_reg <= '0;
                    end
                    REG_MIN_OMEGA: min_reg <= cfg_wr_data;
                    REG_MAX_OMEGA: max_reg <= cfg_wr_data;
                    REG_ALPHA:     alpha_reg <= cfg_wr_data[23:0];
                    REG_BETA:      beta_reg <= cfg_wr_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== bench/tb_fm_stereo_pilot_pll_decoder.sv =====
`default_nettype none

class audio_scoreboard;
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } audio_pair_t;

    int qsine[0:256];
    bit          lpf_on;
    bit [31:0]   omega_nom, omega_lo, omega_hi;
    bit [23:0]   gain_p, gain_i;
    int          pilot_tap[127], audio_tap[127];
    int          pilot_dl[127], sum_dl[127], diff_dl[127], align_dl[64];
    int          fir_ptr, aud_ptr, align_ptr;
    bit [31:0]   vco_ph, vco_inc;
    int          errors;
    audio_pair_t expected_audio[$];

    function new();
        longint unsigned x, x2, term, q;
        longint s;
        for (int i = 0; i <= 256; i++) begin
            x = (longint'(i) * 64'd1686629713) >> 8;
            x2 = (x * x) >> 30;
            term = x;
            s = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) s -= longint'(term);
                else s += longint'(term);
            end
            q = (s > 0) ? (longint'(s) + 16384) >> 15 : 0;
            qsine[i] = (q > 32767) ? 32767 : int'(q);
        end
        lpf_on = 1;
        omega_nom = fspd_pkg::NOMINAL_RST;
        omega_lo = fspd_pkg::MIN_RST;
        omega_hi = fspd_pkg::MAX_RST;
        gain_p = fspd_pkg::ALPHA_RST;
        gain_i = fspd_pkg::BETA_RST;
        foreach (pilot_dl[k]) begin
            pilot_dl[k] = 0; sum_dl[k] = 0; diff_dl[k] = 0;
            pilot_tap[k] = 0; audio_tap[k] = 0;
        end
        foreach (align_dl[k]) align_dl[k] = 0;
        fir_ptr = 0; aud_ptr = 0; align_ptr = 0;
        vco_ph = 0;
        vco_inc = omega_nom;
        errors = 0;
    endfunction

    function longint rshift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function int sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function int sine(bit [31:0] ph);
        bit [9:0] j;
        int v;
        j = ph[31:22];
        v = j[8] ? qsine[256 - j[7:0]] : qsine[j[7:0]];
        return j[9] ? -v : v;
    endfunction

    function longint fir_sum(int c[127], int line[127], int ptr);
        longint acc;
        acc = 0;
        for (int k = 0; k < 127; k++) acc += longint'(c[k]) * line[(ptr + 127 - k) % 127];
        return rshift(acc, 17);
    endfunction

    function void configure(logic [2:0] idx, logic [31:0] val);
        case (idx)
            fspd_pkg::REG_LOW_PASS: begin
                if (val[0] != lpf_on) begin
                    foreach (sum_dl[k]) begin
                        sum_dl[k] = 0; diff_dl[k] = 0;
                    end
                    aud_ptr = 0;
                end
                lpf_on = val[0];
            end
            fspd_pkg::REG_NOMINAL: begin
                omega_nom = val; vco_inc = val; vco_ph = 0;
            end
            fspd_pkg::REG_MIN_OMEGA: omega_lo = val;
            fspd_pkg::REG_MAX_OMEGA: omega_hi = val;
            fspd_pkg::REG_ALPHA: gain_p = val[23:0];
            fspd_pkg::REG_BETA: gain_i = val[23:0];
            default: ;
        endcase
    endfunction

    function void note_word(logic [1:0] op, int idx, int coef, int x);
        bit [31:0] dph;
        longint pilot, p, e, st, sum, diff;
        int delayed, diffin, cs;
        audio_pair_t a;
        if (op == fspd_pkg::OP_LOAD_PILOT) begin
            if (idx < 127) pilot_tap[idx] = coef;
            return;
        end
        if (op == fspd_pkg::OP_LOAD_AUDIO) begin
            if (idx < 127) audio_tap[idx] = coef;
            return;
        end
        if (op != fspd_pkg::OP_SAMPLE) return;

        pilot_dl[fir_ptr] = x;
        pilot = fir_sum(pilot_tap, pilot_dl, fir_ptr);
        fir_ptr = (fir_ptr + 1) % 127;

        dph = vco_ph - 32'(63 * vco_inc);
        p = pilot * sine(dph) * 20;
        if (p >= (longint'(1) <<< 30)) e = 32768;
        else if (p <= -(longint'(1) <<< 30)) e = -32768;
        else e = rshift(p, 15);

        st = longint'(vco_inc) + rshift(longint'(gain_i) * e, 15);
        if (st < longint'(omega_lo)) st = longint'(omega_lo);
        if (st > longint'(omega_hi)) st = longint'(omega_hi);
        vco_inc = st[31:0];
        vco_ph = vco_ph + vco_inc + 32'(rshift(longint'(gain_p) * e, 15));

        delayed = align_dl[align_ptr];
        align_dl[align_ptr] = x;
        align_ptr = (align_ptr + 1) % 64;

        cs = sine(dph * 2 + 32'h4000_0000);
        diffin = sat16(rshift(longint'(delayed) * cs * 2, 15));

        if (lpf_on) begin
            sum_dl[aud_ptr] = delayed;
            diff_dl[aud_ptr] = diffin;
            sum = fir_sum(audio_tap, sum_dl, aud_ptr);
            diff = fir_sum(audio_tap, diff_dl, aud_ptr);
            aud_ptr = (aud_ptr + 1) % 127;
        end else begin
            sum = delayed;
            diff = diffin;
        end
        a.left = 16'(sat16(sum + diff));
        a.right = 16'(sat16(sum - diff));
        expected_audio.push_back(a);
    endfunction

    function void check_audio(logic [15:0] left, logic [15:0] right);
        audio_pair_t a;
        if (expected_audio.size() == 0) begin
            $error("unexpected audio word left=%0d right=%0d",
                   $signed(left), $signed(right));
            errors++;
            return;
        end
        a = expected_audio.pop_front();
        if (left !== a.left) begin
            $error("left_out expected %0d actual %0d", a.left, $signed(left));
            errors++;
        end
        if (right !== a.right) begin
            $error("right_out expected %0d actual %0d", a.right, $signed(right));
            errors++;
        end
    endfunction
endclass

module tb_fm_stereo_pilot_pll_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wr_data;

    audio_scoreboard sb = new();
    int send_idle_pct = 38;
    int recv_idle_pct = 57;
    int stall_count = 0;
    bit [31:0] tone_ph = 0;

    fm_stereo_pilot_pll_decoder u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // sink side with random back-pressure
    initial begin
        m_tready = 0;
        forever begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_audio(m_tdata[15:0], m_tdata[31:16]);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) stall_count = 0;
            else stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_word(logic [1:0] op, int idx, int coef, int x);
        if ($urandom_range(99) < send_idle_pct) begin
            repeat ($urandom_range(1, 5)) begin
                s_tvalid <= 0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {7'd0, 16'(x), 18'(coef), 7'(idx)};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, idx, coef, x);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.configure(idx, val);
    endtask

    // block must be idle before a register write
    task automatic drain();
        s_tvalid <= 0;
        while (sb.expected_audio.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic int mpx_word();
        int v;
        if ($urandom_range(15) == 0) return int'($signed(16'($urandom)));
        v = sb.sine(tone_ph) / 10 + int'($signed(16'($urandom))) / 4
            + sb.sine(tone_ph * 2) / 3;
        tone_ph += 32'd429496730;
        return sb.sat16(v);
    endfunction

    task automatic load_taps(logic [1:0] op, int span);
        for (int k = 0; k < 127; k++)
            send_word(op, k, $urandom_range(2 * span) - span, $urandom);
    endtask

    task automatic random_items(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 88) send_word(fspd_pkg::OP_SAMPLE, $urandom_range(127), $urandom, mpx_word());
            else if (r < 93)
                send_word(fspd_pkg::OP_LOAD_PILOT, $urandom_range(127),
                          $urandom_range(8191) - 4096, $urandom);
            else if (r < 98)
                send_word(fspd_pkg::OP_LOAD_AUDIO, $urandom_range(127),
                          $urandom_range(8191) - 4096, $urandom);
            else send_word(OP_UNUSED, $urandom_range(127), $urandom, $urandom);
        end
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        cfg_wr_en = 0;
        cfg_index = 0;
        cfg_wr_data = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        write_reg(fspd_pkg::REG_LOW_PASS, 1);
        write_reg(fspd_pkg::REG_NOMINAL, fspd_pkg::NOMINAL_RST);
        write_reg(fspd_pkg::REG_MIN_OMEGA, fspd_pkg::MIN_RST);
        write_reg(fspd_pkg::REG_MAX_OMEGA, fspd_pkg::MAX_RST);
        write_reg(fspd_pkg::REG_ALPHA, fspd_pkg::ALPHA_RST);
        write_reg(fspd_pkg::REG_BETA, fspd_pkg::BETA_RST);
        write_reg(REG_SPARE6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE7, 32'h0);

        // every tap written before the first sample
        load_taps(fspd_pkg::OP_LOAD_PILOT, 2048);
        load_taps(fspd_pkg::OP_LOAD_AUDIO, 2048);
        send_word(fspd_pkg::OP_LOAD_PILOT, 0, 131071, 0);
        send_word(fspd_pkg::OP_LOAD_PILOT, 1, -131072, -1);
        send_word(fspd_pkg::OP_LOAD_AUDIO, 0, 131071, 0);
        send_word(fspd_pkg::OP_LOAD_AUDIO, 1, -131072, -1);
        send_word(fspd_pkg::OP_LOAD_PILOT, 127, -1, 0);
        send_word(fspd_pkg::OP_LOAD_AUDIO, 127, -1, 0);
        send_word(OP_UNUSED, 127, -1, -1);
        send_word(fspd_pkg::OP_SAMPLE, 0, 0, 32767);
        send_word(fspd_pkg::OP_SAMPLE, 127, -1, -32768);
        send_word(fspd_pkg::OP_SAMPLE, 0, 0, 0);
        send_word(fspd_pkg::OP_SAMPLE, 0, 0, -1);
        for (int k = 0; k < 8; k++)
            send_word(fspd_pkg::OP_SAMPLE, 0, 0, (k % 2) ? -32768 : 32767);
        send_word(fspd_pkg::OP_LOAD_PILOT, 0, 1000, 0);
        send_word(fspd_pkg::OP_LOAD_PILOT, 1, -1000, 0);
        send_word(fspd_pkg::OP_LOAD_AUDIO, 0, 1000, 0);
        send_word(fspd_pkg::OP_LOAD_AUDIO, 1, -1000, 0);
        random_items(320);
        drain();

        // extremes: bypass, crossed clamp bounds, full gains
        send_idle_pct = 57;
        recv_idle_pct = 38;
        write_reg(fspd_pkg::REG_LOW_PASS, 0);
        write_reg(fspd_pkg::REG_NOMINAL, 32'hFFFF_FFFF);
        write_reg(fspd_pkg::REG_MIN_OMEGA, 32'hFFFF_FFFF);
        write_reg(fspd_pkg::REG_MAX_OMEGA, 32'h0);
        write_reg(fspd_pkg::REG_ALPHA, 32'h00FF_FFFF);
        write_reg(fspd_pkg::REG_BETA, 32'h00FF_FFFF);
        random_items(160);
        drain();
        write_reg(fspd_pkg::REG_NOMINAL, 32'h0);
        write_reg(fspd_pkg::REG_MIN_OMEGA, 32'h0);
        write_reg(fspd_pkg::REG_MAX_OMEGA, 32'hFFFF_FFFF);
        random_items(160);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(fspd_pkg::REG_LOW_PASS, 1);
        write_reg(fspd_pkg::REG_NOMINAL, fspd_pkg::NOMINAL_RST);
        write_reg(fspd_pkg::REG_MIN_OMEGA, fspd_pkg::MIN_RST);
        write_reg(fspd_pkg::REG_MAX_OMEGA, fspd_pkg::MAX_RST);
        write_reg(fspd_pkg::REG_ALPHA, 32'h0);
        write_reg(fspd_pkg::REG_BETA, 32'h0);
        random_items(100);
        drain();
        write_reg(fspd_pkg::REG_ALPHA, fspd_pkg::ALPHA_RST);
        write_reg(fspd_pkg::REG_BETA, fspd_pkg::BETA_RST);
        random_items(230);
        drain();

        if (sb.expected_audio.size() != 0) begin
            $error("%0d audio words never arrived", sb.expected_audio.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== fm_stereo_pilot_pll_decoder.f =====
src/fspd_pkg.sv
src/fspd_mac.sv
src/fm_stereo_pilot_pll_decoder.sv
bench/tb_fm_stereo_pilot_pll_decoder.sv
